FILE: rtl/sba_pkg.sv
// Shared constants, operation and status codes, and the word priority encoder.
package sba_pkg;

  // Bitmap word geometry
  localparam int WORD_W      = 32;
  localparam int WORD_BIT_W  = 5;

  // Default map size
  localparam int DEF_MAX_SLOTS = 256;

  // Field widths
  localparam int SLOTS_CFG_W = 9;
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 9;
  localparam int STATUS_W    = 3;
  localparam int FOUND_W     = 8;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = 9'd256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET       = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND_FREE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND_NEXT = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EOF     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_NEXT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  // Lowest set bit of a word: {hit, index}
  function automatic logic [WORD_BIT_W:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [WORD_BIT_W:0] res;
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        res = {1'b1, WORD_BIT_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/sba_ifs.sv
// Request and response channel interfaces.
interface sba_req_if;
  import sba_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [SLOT_W-1:0] slot;
  logic                     value;
  modport source(output valid, op, slot, value, input ready);
  modport sink(input valid, op, slot, value, output ready);
endinterface

interface sba_rsp_if;
  import sba_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [FOUND_W-1:0]      found_slot;
  logic                    map_full;
  modport source(output valid, status, found_slot, map_full, input ready);
  modport sink(input valid, status, found_slot, map_full, output ready);
endinterface

FILE: rtl/slot_bitmap_allocator.sv
// Occupancy bitmap with set, find-first-free and find-next-used operations.
// Range errors, end-of-map and the unused op go straight to the result state;
// set_slot does a read-modify-write of one word, and the find ops scan up to the last live word.
// Throughput: one request at a time; the scan reads one 32-bit word per cycle
// through one encoder.
// Reset (and any slots_in_use write) frees every slot at once through per-word
// valid bits; reset sets slots_in_use to 256.
module slot_bitmap_allocator #(
  parameter int MAX_SLOTS = sba_pkg::DEF_MAX_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sba_pkg::SLOTS_CFG_W-1:0]  cfg_wr_data,
  sba_req_if.sink                          req,
  sba_rsp_if.source                        rsp
);
  import sba_pkg::*;

  localparam int NUM_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int EXT_W     = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

  localparam int                STATE_W = 2;
  localparam logic [STATE_W-1:0] S_IDLE = 2'd0;
  localparam logic [STATE_W-1:0] S_SCAN = 2'd1;
  localparam logic [STATE_W-1:0] S_OUT  = 2'd2;

  logic [STATE_W-1:0]     state, state_next;
  logic [SLOTS_CFG_W-1:0] slots_in_use;
  logic [CNT_W-1:0]       used_count, used_count_next;
  logic [WIDX_W-1:0]      cur_word, cur_word_next;
  logic                   first_word, first_word_next;
  logic [WORD_BIT_W-1:0]  start_bit, start_bit_next;
  logic [OP_W-1:0]        op_q, op_q_next;
  logic                   bit_q, bit_q_next;
  logic [STATUS_W-1:0]    status_q, status_q_next;
  logic [FOUND_W-1:0]     found_q, found_q_next;

  logic [EXT_W-1:0]        n_ext, last_ext, pos_ext, hit_pos;
  logic signed [EXT_W-1:0] slot_x, last_s;
  logic [WIDX_W-1:0]       last_word, start_word, rd_addr;
  logic [WORD_BIT_W-1:0]   last_bit;
  logic [WORD_W-1:0]       rd_data, wr_data, lo_mask, hi_mask, cand;
  logic [WORD_BIT_W:0]     enc;
  logic                    wr_en, old_bit;

  // Effective slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (slots_in_use == '0) begin
      n_ext = EXT_W'(1);
    end else if (EXT_W'(slots_in_use) > EXT_W'(MAX_SLOTS)) begin
      n_ext = EXT_W'(MAX_SLOTS);
    end else begin
      n_ext = EXT_W'(slots_in_use);
    end
  end

  assign last_ext  = n_ext - EXT_W'(1);
  assign last_s    = signed'(last_ext);
  assign last_word = WIDX_W'(last_ext >> WORD_BIT_W);
  assign last_bit  = last_ext[WORD_BIT_W-1:0];

  // Start position of the incoming request
  assign slot_x = EXT_W'(req.slot);
  always_comb begin
    case (req.op)
      OP_FIND_NEXT: pos_ext = unsigned'(slot_x + EXT_W'(1));
      OP_SET:       pos_ext = unsigned'(slot_x);
      default:      pos_ext = '0;
    endcase
  end
  assign start_word = WIDX_W'(pos_ext >> WORD_BIT_W);

  // Fetch the start word on accept, the following word while scanning
  assign rd_addr = (state == S_IDLE) ? start_word : cur_word + WIDX_W'(1);

  sba_word_store #(
    .NUM_WORDS(NUM_WORDS),
    .WIDX_W   (WIDX_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_wr_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(cur_word),
    .wr_data(wr_data)
  );

  // Shared word search: invert for free search, trim to the live range
  assign lo_mask = first_word ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}};
  assign hi_mask = (cur_word == last_word)
                 ? ({WORD_W{1'b1}} >> (WORD_BIT_W'(WORD_W - 1) - last_bit))
                 : {WORD_W{1'b1}};
  assign cand    = ((op_q == OP_FIND_FREE) ? ~rd_data : rd_data) & lo_mask & hi_mask;
  assign enc     = lowest_set(cand);
  assign hit_pos = (EXT_W'(cur_word) << WORD_BIT_W) | EXT_W'(enc[WORD_BIT_W-1:0]);

  // Read-modify-write of one bit for set_slot
  assign old_bit = rd_data[start_bit];
  always_comb begin
    wr_data            = rd_data;
    wr_data[start_bit] = bit_q;
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    used_count_next = used_count;
    cur_word_next   = cur_word;
    first_word_next = first_word;
    start_bit_next  = start_bit;
    op_q_next       = op_q;
    bit_q_next      = bit_q;
    status_q_next   = status_q;
    found_q_next    = found_q;
    wr_en           = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_q_next       = req.op;
          bit_q_next      = req.value;
          cur_word_next   = start_word;
          first_word_next = 1'b1;
          start_bit_next  = pos_ext[WORD_BIT_W-1:0];
          found_q_next    = '0;
          status_q_next   = ST_OK;
          state_next      = S_SCAN;
          case (req.op)
            OP_SET: begin
              if (slot_x < 0 || slot_x > last_s) begin
                status_q_next = ST_RANGE;
                state_next    = S_OUT;
              end
            end
            OP_FIND_FREE: begin
              state_next = S_SCAN;
            end
            OP_FIND_NEXT: begin
              if (slot_x < -1 || slot_x > last_s) begin
                status_q_next = ST_RANGE;
                state_next    = S_OUT;
              end else if (slot_x == last_s) begin
                status_q_next = ST_EOF;
                state_next    = S_OUT;
              end
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (op_q == OP_SET) begin
          wr_en = 1'b1;
          if (!old_bit && bit_q) begin
            used_count_next = used_count + CNT_W'(1);
          end else if (old_bit && !bit_q) begin
            used_count_next = used_count - CNT_W'(1);
          end
          state_next = S_OUT;
        end else if (enc[WORD_BIT_W]) begin
          found_q_next = hit_pos[FOUND_W-1:0];
          state_next   = S_OUT;
        end else if (cur_word == last_word) begin
          status_q_next = (op_q == OP_FIND_FREE) ? ST_NO_FREE : ST_NO_NEXT;
          state_next    = S_OUT;
        end else begin
          cur_word_next   = cur_word + WIDX_W'(1);
          first_word_next = 1'b0;
        end
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slots_in_use <= SLOTS_RESET;
      used_count   <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        slots_in_use <= cfg_wr_data;
        used_count   <= '0;
      end else begin
        used_count <= used_count_next;
      end
    end
  end

  // Request context and result payload
  always_ff @(posedge clk) begin
    cur_word   <= cur_word_next;
    first_word <= first_word_next;
    start_bit  <= start_bit_next;
    op_q       <= op_q_next;
    bit_q      <= bit_q_next;
    status_q   <= status_q_next;
    found_q    <= found_q_next;
  end

  // Channel outputs
  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = (state == S_OUT);
  assign rsp.status     = status_q;
  assign rsp.found_slot = found_q;
  assign rsp.map_full   = (EXT_W'(used_count) == n_ext);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    EXT_W'(used_count) <= n_ext)
    else $error("used count exceeds slot count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(rsp.valid && req.ready))
    else $error("request taken while a result is pending");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cur_word <= last_word))
    else $error("scan ran past the last live word");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (used_count == '0))
    else $error("config write did not clear the used count");

  a_write_only_on_set: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_SCAN && op_q == OP_SET))
    else $error("bitmap written outside a set operation");

endmodule

FILE: rtl/sba_word_store.sv
// Bitmap word memory with per-word valid bits and a registered read port.
module sba_word_store #(
  parameter int NUM_WORDS = 8,
  parameter int WIDX_W    = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic [WIDX_W-1:0]         rd_addr,
  output logic [sba_pkg::WORD_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [WIDX_W-1:0]         wr_addr,
  input  logic [sba_pkg::WORD_W-1:0] wr_data
);
  import sba_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_valid;
  logic [WORD_W-1:0]    mem_q;
  logic                 valid_q;

  // Track which words hold written data; clear drops them all at once
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[wr_addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_valid[rd_addr];
    end
  end

  // Unwritten words read as all free
  assign rd_data = valid_q ? mem_q : '0;

endmodule

FILE: test/tb_slot_bitmap_allocator.sv
// Self-checking testbench for the slot bitmap allocator: directed table, then random phases.
module tb_slot_bitmap_allocator;
  import sba_pkg::*;

  localparam int MAX_SLOTS        = DEF_MAX_SLOTS;
  localparam int RSP_HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int PHASE_ITEMS      = 45;

  // Op code the block leaves unused, and the slot codes for -1 (scan from the start) and the most negative value
  localparam logic [OP_W-1:0]          OP_UNUSED       = 2'd3;
  localparam logic signed [SLOT_W-1:0] SCAN_FROM_START = 9'h1FF;
  localparam logic signed [SLOT_W-1:0] SLOT_MOST_NEG   = 9'h100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_slot;
    logic                map_full;
  } rsp_beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [SLOTS_CFG_W-1:0]     cfg_val;
    logic [OP_W-1:0]            op;
    logic signed [SLOT_W-1:0]   slot;
    logic                       value;
    logic                       pinned;
    rsp_beat_t                  want;
  } dir_row_t;

  // Directed rows; pinned rows carry the result read straight off the spec
  localparam int DIR_ROWS_N = 27;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{ROW_ITEM, 9'd0,   OP_FIND_FREE, 9'sd0,           1'b0, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, SCAN_FROM_START, 1'b0, 1'b1, '{ST_NO_NEXT, 8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, 9'sd255,         1'b0, 1'b1, '{ST_EOF,     8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, -9'sd2,          1'b1, 1'b1, '{ST_RANGE,   8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, SLOT_MOST_NEG,   1'b0, 1'b1, '{ST_RANGE,   8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_SET,       SCAN_FROM_START, 1'b1, 1'b1, '{ST_RANGE,   8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_SET,       SLOT_MOST_NEG,   1'b1, 1'b1, '{ST_RANGE,   8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd0,           1'b1, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd255,         1'b1, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_FREE, 9'sd0,           1'b0, 1'b1, '{ST_OK,      8'd1,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, SCAN_FROM_START, 1'b0, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, 9'sd0,           1'b0, 1'b1, '{ST_OK,      8'd255, 1'b0}},
    '{ROW_ITEM, 9'd0,   OP_UNUSED,    9'sd170,         1'b1, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd0,           1'b0, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_FREE, 9'sd0,           1'b0, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd85,          1'b1, 1'b0, '0},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, 9'sd1,           1'b0, 1'b0, '0},
    // zero slots in use counts as one
    '{ROW_CFG,  9'd0,   OP_SET,       9'sd0,           1'b0, 1'b0, '0},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd0,           1'b1, 1'b1, '{ST_OK,      8'd0,   1'b1}},
    '{ROW_ITEM, 9'd0,   OP_FIND_FREE, 9'sd0,           1'b0, 1'b1, '{ST_NO_FREE, 8'd0,   1'b1}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, 9'sd0,           1'b0, 1'b1, '{ST_EOF,     8'd0,   1'b1}},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd1,           1'b1, 1'b1, '{ST_RANGE,   8'd0,   1'b1}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, 9'sd1,           1'b0, 1'b1, '{ST_RANGE,   8'd0,   1'b1}},
    // oversized count clamps to the full map
    '{ROW_CFG,  9'd511, OP_SET,       9'sd0,           1'b0, 1'b0, '0},
    '{ROW_ITEM, 9'd0,   OP_SET,       9'sd255,         1'b1, 1'b1, '{ST_OK,      8'd0,   1'b0}},
    '{ROW_ITEM, 9'd0,   OP_FIND_NEXT, 9'sd254,         1'b0, 1'b0, '0},
    '{ROW_ITEM, 9'd0,   OP_FIND_FREE, 9'sd0,           1'b0, 1'b1, '{ST_OK,      8'd0,   1'b0}}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [SLOTS_CFG_W-1:0] cfg_wr_data;

  sba_req_if req_ch();
  sba_rsp_if rsp_ch();

  slot_bitmap_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow bitmap and slot count
  bit                     slot_used [MAX_SLOTS];
  logic [SLOTS_CFG_W-1:0] slot_count;

  rsp_beat_t pending_rsp_q [$];
  logic      pin_en;
  rsp_beat_t pin_beat;
  int        req_idle_pct;
  int        rsp_idle_pct;
  bit        rsp_hold_req = 1'b0;
  int        beats_sent;
  int        beats_rcvd = 0;
  int        quiet_cycles;
  bit        failed = 1'b0;

  function automatic int active_slot_count();
    if (slot_count == 0) return 1;
    if (slot_count > MAX_SLOTS) return MAX_SLOTS;
    return int'(slot_count);
  endfunction

  // Apply one request to the shadow bitmap and return the beat it yields
  function automatic rsp_beat_t apply_bitmap_op(input logic [OP_W-1:0] op,
                                                input logic signed [SLOT_W-1:0] slot,
                                                input logic value);
    rsp_beat_t r;
    int        n;
    int        s;
    bit        hit;
    n = active_slot_count();
    s = int'(slot);
    hit = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_SET: begin
        if (s < 0 || s >= n) r.status = ST_RANGE;
        else slot_used[s] = value;
      end
      OP_FIND_FREE: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < n && !hit; i++) begin
          if (!slot_used[i]) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_slot = FOUND_W'(i);
          end
        end
      end
      OP_FIND_NEXT: begin
        if (s < -1 || s > n - 1) begin
          r.status = ST_RANGE;
        end else if (s == n - 1) begin
          r.status = ST_EOF;
        end else begin
          r.status = ST_NO_NEXT;
          for (int i = s + 1; i < n && !hit; i++) begin
            if (slot_used[i]) begin
              hit = 1'b1;
              r.status = ST_OK;
              r.found_slot = FOUND_W'(i);
            end
          end
        end
      end
      default: ;
    endcase
    r.map_full = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!slot_used[i]) r.map_full = 1'b0;
    end
    return r;
  endfunction

  // Offer one request beat after random idle cycles, hold until accepted
  task automatic offer_req(input logic [OP_W-1:0] op, input logic signed [SLOT_W-1:0] slot,
                           input logic value, input logic pinned, input rsp_beat_t want);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.slot  <= slot;
    req_ch.value <= value;
    pin_en       <= pinned;
    pin_beat     <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and hold until every expected beat has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (beats_rcvd < beats_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [SLOTS_CFG_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: random backpressure plus one long hold on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp_ch.ready <= !rst && ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Track accepted beats: check responses, predict requests, follow config writes
  always @(posedge clk) begin
    rsp_beat_t want;
    rsp_beat_t seen;
    rsp_beat_t pred;
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      slot_count = SLOTS_RESET;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen = '{rsp_ch.status, rsp_ch.found_slot, rsp_ch.map_full};
        beats_rcvd++;
        if (pending_rsp_q.size() == 0) begin
          $error("response beat with nothing expected: status %0d found_slot %0d map_full %0d",
                 seen.status, seen.found_slot, seen.map_full);
          failed = 1'b1;
        end else begin
          want = pending_rsp_q.pop_front();
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            failed = 1'b1;
          end
          if (seen.found_slot !== want.found_slot) begin
            $error("found_slot: expected %0d, got %0d", want.found_slot, seen.found_slot);
            failed = 1'b1;
          end
          if (seen.map_full !== want.map_full) begin
            $error("map_full: expected %0d, got %0d", want.map_full, seen.map_full);
            failed = 1'b1;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pred = apply_bitmap_op(req_ch.op, req_ch.slot, req_ch.value);
        pending_rsp_q.push_back(pin_en ? pin_beat : pred);
      end
      if (cfg_wr_en) begin
        slot_count = cfg_wr_data;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [SLOTS_CFG_W-1:0]   sizes [3];
    logic [OP_W-1:0]          op;
    logic signed [SLOT_W-1:0] slot;
    logic                     value;
    int                       n;
    int                       pick;
    req_ch.valid <= 1'b0;
    req_ch.op    <= '0;
    req_ch.slot  <= '0;
    req_ch.value <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    pin_en       <= 1'b0;
    pin_beat     <= '0;
    rst          <= 1'b1;
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    beats_sent   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_CFG)
        write_slot_count(DIR_ROWS[r].cfg_val);
      else
        offer_req(DIR_ROWS[r].op, DIR_ROWS[r].slot, DIR_ROWS[r].value,
                  DIR_ROWS[r].pinned, DIR_ROWS[r].want);
    end

    // Random phases: sender-light, receiver-light, then no idling
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          req_idle_pct = 21;
          rsp_idle_pct = 86;
          sizes = '{9'd1, 9'd33, 9'd256};
        end
        1: begin
          req_idle_pct = 86;
          rsp_idle_pct = 21;
          sizes = '{9'd2, SLOTS_CFG_W'($urandom_range(511, 257)), 9'd32};
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
          sizes = '{SLOTS_CFG_W'($urandom_range(256, 1)), 9'd64, 9'd256};
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        write_slot_count(sizes[k]);
        // long response hold while requests keep coming
        if (mode == 2 && k == 1) rsp_hold_req = 1'b1;
        // size the random slots from the count just written
        if (sizes[k] == '0) n = 1;
        else if (sizes[k] > MAX_SLOTS) n = MAX_SLOTS;
        else n = int'(sizes[k]);
        for (int j = 0; j < PHASE_ITEMS; j++) begin
          pick  = $urandom_range(99);
          slot  = SLOT_W'($urandom_range(511, 0));
          value = 1'($urandom_range(1, 0));
          if (pick < 45) begin
            op    = OP_SET;
            slot  = SLOT_W'($urandom_range(n - 1, 0));
            value = ($urandom_range(99) < 70);
          end else if (pick < 60) begin
            op = OP_FIND_FREE;
          end else if (pick < 85) begin
            op = OP_FIND_NEXT;
            case ($urandom_range(4, 0))
              0: slot = SCAN_FROM_START;
              1: slot = SLOT_W'(n - 1);
              default: slot = SLOT_W'($urandom_range(n - 1, 0));
            endcase
          end else if (pick < 95) begin
            // unconstrained slot, often out of range
            op = ($urandom_range(1, 0) != 0) ? OP_SET : OP_FIND_NEXT;
          end else begin
            op = OP_UNUSED;
          end
          offer_req(op, slot, value, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_rsp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending_rsp_q.size() != 0)
        $error("%0d expected response beats never arrived", pending_rsp_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sba_pkg.sv
rtl/sba_ifs.sv
rtl/sba_word_store.sv
rtl/slot_bitmap_allocator.sv
test/tb_slot_bitmap_allocator.sv
